>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks in the stationary detector RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/asd_pkg.sv
// ----------------------------------------------------------------------------
// asd_pkg
// Widths, reset values, register codes and state types of the detector.
// ----------------------------------------------------------------------------
package asd_pkg;

    // Default window depth.
    localparam int WINDOW_LEN_DEF = 16;

    // Field and datapath widths.
    localparam int ACCEL_W   = 16;
    localparam int AXIS_W    = 17;   // magnitude of one axis, 0..32768
    localparam int RAD_W     = 32;   // sum of three squared axes
    localparam int MAG_W     = 16;
    localparam int SQ_W      = 32;   // squared magnitude
    localparam int MEAN_W    = 16;
    localparam int VAR_W     = 30;
    localparam int VTH_W     = 32;
    localparam int MTH_W     = 16;
    localparam int ONE_G_W   = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // Magnitude constants.
    localparam logic [MAG_W-1:0] MAG_RESET = 16'd16384;
    localparam logic [MAG_W-1:0] MAG_MAX   = 16'd56755;

    // Register reset values.
    localparam logic [VTH_W-1:0]   VAR_THRESH_RST = 32'd268435;
    localparam logic [MTH_W-1:0]   MAG_THRESH_RST = 16'd1638;
    localparam logic [ONE_G_W-1:0] ONE_G_RST      = 15'd16384;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VAR_THRESH = 2'd0,
        CFG_MAG_THRESH = 2'd1,
        CFG_ONE_G      = 2'd2
    } t_cfg_idx;

    // Configuration seen by the back part.
    typedef struct packed {
        logic [VTH_W-1:0]   var_thresh;
        logic [MTH_W-1:0]   mag_thresh;
        logic [ONE_G_W-1:0] one_g;
    } t_cfg;

    // Front part states.
    typedef enum logic [1:0] {
        F_IDLE,
        F_SQUARE,
        F_ROOT,
        F_PUSH
    } t_front_state;

    // Back part states.
    typedef enum logic [2:0] {
        B_IDLE,
        B_SQUARE,
        B_SUMS,
        B_PRODUCT,
        B_SPREAD,
        B_CHECK,
        B_DIVIDE,
        B_OUTPUT
    } t_back_state;

endpackage

>>> rtl/asd_front.sv
// ----------------------------------------------------------------------------
// asd_front
// Takes a sample, squares the three axes on one shared multiplier and forms
// the integer square root one result bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module asd_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic signed [asd_pkg::ACCEL_W-1:0] i_accel_x,
    input  logic signed [asd_pkg::ACCEL_W-1:0] i_accel_y,
    input  logic signed [asd_pkg::ACCEL_W-1:0] i_accel_z,
    output logic                               o_full,
    output logic                               o_mag_push,
    output logic [asd_pkg::MAG_W-1:0]          o_mag,
    input  logic                               i_mag_full
);
    import asd_pkg::*;

    localparam int NUM_AXES = 3;
    localparam int SQA_W    = 2 * AXIS_W;
    localparam logic [RAD_W-1:0] ROOT_BIT0 = RAD_W'(1) << (RAD_W - 2);

    t_front_state     r_state, n_state;
    logic [AXIS_W-1:0] r_abs [NUM_AXES];
    logic [1:0]        r_axis;
    logic [RAD_W-1:0]  r_rad;
    logic [RAD_W-1:0]  r_res;
    logic [RAD_W-1:0]  r_bit;
    logic [SQA_W-1:0]  axis_sq;
    logic [RAD_W:0]    trial;
    logic              take_bit;
    logic              accept;
    logic              last_axis;
    logic              last_bit;

    // Absolute value of a two's complement axis reading.
    function automatic logic [AXIS_W-1:0] abs_axis(input logic signed [ACCEL_W-1:0] v);
        logic [AXIS_W-1:0] ext;
        ext = {1'b0, v};
        return v[ACCEL_W-1] ? (AXIS_W'(1) << ACCEL_W) - ext : ext;
    endfunction

    // Shared squaring multiplier and root trial subtraction.
    assign axis_sq   = SQA_W'(r_abs[r_axis]) * SQA_W'(r_abs[r_axis]);
    assign trial     = {1'b0, r_res} + {1'b0, r_bit};
    assign take_bit  = ({1'b0, r_rad} >= trial);
    assign accept    = i_push && !o_full;
    assign last_axis = (r_axis == 2'(NUM_AXES - 1));
    assign last_bit  = (r_bit == RAD_W'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:   if (accept) n_state = F_SQUARE;
            F_SQUARE: if (last_axis) n_state = F_ROOT;
            F_ROOT:   if (last_bit) n_state = F_PUSH;
            F_PUSH:   if (!i_mag_full) n_state = F_IDLE;
            default:  n_state = F_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_full     = (r_state != F_IDLE);
        o_mag_push = (r_state == F_PUSH) && !i_mag_full;
        o_mag      = r_res[MAG_W-1:0];
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath: capture, accumulate squares, then one root bit per cycle.
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    r_abs[0] <= abs_axis(i_accel_x);
                    r_abs[1] <= abs_axis(i_accel_y);
                    r_abs[2] <= abs_axis(i_accel_z);
                    r_axis   <= '0;
                    r_rad    <= '0;
                end
            end
            F_SQUARE: begin
                r_rad  <= r_rad + axis_sq[RAD_W-1:0];
                r_axis <= r_axis + 2'd1;
                r_res  <= '0;
                r_bit  <= ROOT_BIT0;
            end
            F_ROOT: begin
                if (take_bit) begin
                    r_rad <= r_rad - trial[RAD_W-1:0];
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            default: begin
            end
        endcase
    end

    // A finished root never exceeds the magnitude of the largest sample.
    `ASSERT_IMPLY(a_root_in_range, i_clk, i_rst_n, r_state == F_PUSH,
        r_res <= RAD_W'(MAG_MAX), "square root result out of range")

endmodule

>>> rtl/asd_fifo.sv
// ----------------------------------------------------------------------------
// asd_fifo
// Short queue of magnitudes between the front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module asd_fifo (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [asd_pkg::MAG_W-1:0] i_data,
    output logic                      o_full,
    input  logic                      i_pop,
    output logic [asd_pkg::MAG_W-1:0] o_data,
    output logic                      o_empty
);
    import asd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [MAG_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            if (do_pop) r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

    // The front part must hold its magnitude while the queue is full.
    `ASSERT_IMPLY(a_no_push_when_full, i_clk, i_rst_n, i_push, !o_full,
        "magnitude request pushed into a full queue")

endmodule

>>> rtl/asd_div.sv
// ----------------------------------------------------------------------------
// asd_div
// Division by a fixed divisor through multiplication with a scaled
// reciprocal. The product is built from 16 by 16 bit partial products, one
// per cycle, one for each pair of operand limbs.
// ----------------------------------------------------------------------------
module asd_div #(
    parameter int DIVIDEND_W = 20,
    parameter int QUOT_W     = 16,
    parameter int DIVISOR    = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    output logic                  o_busy,
    output logic [QUOT_W-1:0]     o_quotient
);
    localparam int LIMB_W  = 16;
    localparam int PART_W  = 2 * LIMB_W;
    localparam int N_LIMBS = (DIVIDEND_W + LIMB_W - 1) / LIMB_W;
    localparam int RECIP_W = DIVIDEND_W + 2;
    localparam int M_LIMBS = (RECIP_W + LIMB_W - 1) / LIMB_W;
    localparam int NP_W    = N_LIMBS * LIMB_W;
    localparam int MP_W    = M_LIMBS * LIMB_W;
    localparam int ACC_W   = NP_W + MP_W;
    localparam int SHIFT   = DIVIDEND_W + $clog2(DIVISOR);
    localparam int SCALE_W = SHIFT + 1;
    localparam int NI_W    = $clog2(N_LIMBS + 1);
    localparam int MI_W    = $clog2(M_LIMBS + 1);
    localparam int POS_W   = $clog2(N_LIMBS + M_LIMBS);

    // Reciprocal rounded up; with this scale the floor is exact for every
    // dividend of DIVIDEND_W bits.
    localparam logic [SCALE_W-1:0] SCALE = {1'b1, {SHIFT{1'b0}}};
    localparam logic [SCALE_W-1:0] RECIP_FULL =
        (SCALE + SCALE_W'(DIVISOR - 1)) / SCALE_W'(DIVISOR);
    localparam logic [MP_W-1:0] RECIP = MP_W'(RECIP_FULL);

    logic              r_busy;
    logic [NI_W-1:0]   r_ni;
    logic [MI_W-1:0]   r_mi;
    logic [NP_W-1:0]   r_n;
    logic [MP_W-1:0]   r_m;
    logic [ACC_W-1:0]  r_acc;
    logic [PART_W-1:0] part;
    logic [POS_W-1:0]  pos;
    logic              last_ni;
    logic              last_mi;

    // One limb product per cycle, placed by the sum of the limb positions.
    assign part       = PART_W'(r_n[LIMB_W-1:0]) * PART_W'(r_m[LIMB_W-1:0]);
    assign pos        = POS_W'(r_ni) + POS_W'(r_mi);
    assign last_ni    = (r_ni == NI_W'(N_LIMBS - 1));
    assign last_mi    = (r_mi == MI_W'(M_LIMBS - 1));
    assign o_busy     = r_busy;
    assign o_quotient = r_acc[SHIFT +: QUOT_W];

    // Step control over dividend limbs within reciprocal limbs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ni   <= '0;
            r_mi   <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_ni   <= '0;
            r_mi   <= '0;
        end else if (r_busy) begin
            if (last_ni) begin
                r_ni <= '0;
                r_mi <= r_mi + MI_W'(1);
                if (last_mi) r_busy <= 1'b0;
            end else begin
                r_ni <= r_ni + NI_W'(1);
            end
        end
    end

    // Operand limbs and product accumulator.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= NP_W'(i_dividend);
            r_m   <= RECIP;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + (ACC_W'(part) << (LIMB_W * int'(pos)));
            r_n   <= {r_n[LIMB_W-1:0], r_n[NP_W-1:LIMB_W]};
            if (last_ni) r_m <= r_m >> LIMB_W;
        end
    end

endmodule

>>> rtl/asd_back.sv
// ----------------------------------------------------------------------------
// asd_back
// Window ring, running sums, threshold tests and the mean and variance
// dividers, with a one-entry result register toward the output side.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module asd_back #(
    parameter int WINDOW_LEN = asd_pkg::WINDOW_LEN_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  asd_pkg::t_cfg              i_cfg,
    input  logic                       i_mag_empty,
    input  logic [asd_pkg::MAG_W-1:0]  i_mag,
    output logic                       o_mag_pop,
    input  logic                       i_pop,
    output logic                       o_empty,
    output logic                       o_stationary,
    output logic [asd_pkg::MEAN_W-1:0] o_mean_magnitude,
    output logic [asd_pkg::VAR_W-1:0]  o_magnitude_variance
);
    import asd_pkg::*;

    localparam int CW   = $clog2(WINDOW_LEN);
    localparam int S1_W = MAG_W + CW;
    localparam int S2_W = SQ_W + CW;
    localparam int SP_W = SQ_W + 2 * CW;
    localparam logic [S1_W-1:0] S1_RST = S1_W'(longint'(WINDOW_LEN) * longint'(MAG_RESET));
    localparam logic [S2_W-1:0] S2_RST =
        S2_W'(longint'(WINDOW_LEN) * longint'(MAG_RESET) * longint'(MAG_RESET));
    localparam logic [CW-1:0]   SLOT_LAST = CW'(WINDOW_LEN - 1);
    localparam logic [SP_W-1:0] W_SP  = SP_W'(WINDOW_LEN);
    localparam logic [SP_W-1:0] WW_SP = SP_W'(WINDOW_LEN * WINDOW_LEN);
    localparam logic [S1_W-1:0] W_S1  = S1_W'(WINDOW_LEN);

    t_back_state        r_state, n_state;
    logic [MAG_W-1:0]   r_mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0] r_entry_valid;
    logic [CW-1:0]      r_slot;
    logic [MAG_W-1:0]   r_rd_data;
    logic               r_rd_valid;
    logic [MAG_W-1:0]   r_mag;
    logic [MAG_W-1:0]   r_old;
    logic [SQ_W-1:0]    r_old_sq;
    logic [SQ_W-1:0]    r_mag_sq;
    logic [S1_W-1:0]    r_s1;
    logic [S2_W-1:0]    r_s2;
    logic [SP_W-1:0]    r_ws2;
    logic [SP_W-1:0]    r_s1sq;
    logic [S1_W-1:0]    r_dev;
    logic [S1_W-1:0]    r_mean_lim;
    logic [SP_W-1:0]    r_var_lim;
    logic [SP_W-1:0]    r_spread;
    logic               r_mean_ok;
    logic               r_out_valid;
    logic               r_out_stationary;
    logic [MEAN_W-1:0]  r_out_mean;
    logic [VAR_W-1:0]   r_out_var;
    logic [MAG_W-1:0]   old_mag;
    logic [S1_W-1:0]    target;
    logic               div_start;
    logic               mean_busy;
    logic               var_busy;
    logic [MEAN_W-1:0]  mean_q;
    logic [VAR_W-1:0]   var_q;
    logic               out_free;
    logic               out_load;

    // An entry never written since reset reads as one g.
    assign old_mag  = r_rd_valid ? r_rd_data : MAG_RESET;
    assign target   = S1_W'(i_cfg.one_g) * W_S1;
    assign out_free = !r_out_valid || i_pop;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:    if (!i_mag_empty) n_state = B_SQUARE;
            B_SQUARE:  n_state = B_SUMS;
            B_SUMS:    n_state = B_PRODUCT;
            B_PRODUCT: n_state = B_SPREAD;
            B_SPREAD:  n_state = B_CHECK;
            B_CHECK:   n_state = B_DIVIDE;
            B_DIVIDE:  if (!mean_busy && !var_busy) n_state = B_OUTPUT;
            B_OUTPUT:  if (out_free) n_state = B_IDLE;
            default:   n_state = B_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_mag_pop = (r_state == B_IDLE) && !i_mag_empty;
        div_start = (r_state == B_CHECK);
        out_load  = (r_state == B_OUTPUT) && out_free;
    end

    // Sequencer, ring pointer, valid bits and result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= B_IDLE;
            r_slot        <= '0;
            r_entry_valid <= '0;
            r_s1          <= S1_RST;
            r_s2          <= S2_RST;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_SUMS) begin
                r_s1 <= r_s1 - S1_W'(r_old) + S1_W'(r_mag);
                r_s2 <= r_s2 - S2_W'(r_old_sq) + S2_W'(r_mag_sq);
                r_entry_valid[r_slot] <= 1'b1;
                r_slot <= (r_slot == SLOT_LAST) ? '0 : r_slot + CW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Window memory with registered read.
    always_ff @(posedge i_clk) begin
        r_rd_data  <= r_mem[r_slot];
        r_rd_valid <= r_entry_valid[r_slot];
        if (r_state == B_SUMS) r_mem[r_slot] <= r_mag;
    end

    // Statistics datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_mag <= i_mag;
            end
            B_SQUARE: begin
                r_old    <= old_mag;
                r_old_sq <= SQ_W'(old_mag) * SQ_W'(old_mag);
                r_mag_sq <= SQ_W'(r_mag) * SQ_W'(r_mag);
            end
            B_PRODUCT: begin
                r_ws2      <= SP_W'(r_s2) * W_SP;
                r_s1sq     <= SP_W'(r_s1) * SP_W'(r_s1);
                r_dev      <= (r_s1 >= target) ? r_s1 - target : target - r_s1;
                r_mean_lim <= S1_W'(i_cfg.mag_thresh) * W_S1;
                r_var_lim  <= SP_W'(i_cfg.var_thresh) * WW_SP;
            end
            B_SPREAD: begin
                r_spread  <= r_ws2 - r_s1sq;
                r_mean_ok <= (r_dev < r_mean_lim);
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_stationary <= (r_spread < r_var_lim) && r_mean_ok;
            r_out_mean       <= mean_q;
            r_out_var        <= var_q;
        end
    end

    // Mean: window sum over the window length.
    asd_div #(
        .DIVIDEND_W (S1_W),
        .QUOT_W     (MEAN_W),
        .DIVISOR    (WINDOW_LEN)
    ) u_mean_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_s1),
        .o_busy     (mean_busy),
        .o_quotient (mean_q)
    );

    // Variance: spread over the squared window length.
    asd_div #(
        .DIVIDEND_W (SP_W),
        .QUOT_W     (VAR_W),
        .DIVISOR    (WINDOW_LEN * WINDOW_LEN)
    ) u_var_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_spread),
        .o_busy     (var_busy),
        .o_quotient (var_q)
    );

    assign o_empty              = !r_out_valid;
    assign o_stationary         = r_out_stationary;
    assign o_mean_magnitude     = r_out_mean;
    assign o_magnitude_variance = r_out_var;

    // Both dividers are launched together by the check step.
    `ASSERT_NEXT(a_div_launched, i_clk, i_rst_n, r_state == B_CHECK,
        mean_busy && var_busy, "dividers did not start")

    // Results are only taken once both dividers have finished.
    `ASSERT_IMPLY(a_div_done_at_output, i_clk, i_rst_n, r_state == B_OUTPUT,
        !mean_busy && !var_busy, "result taken while a divider is busy")

    // The scaled square sum never falls below the squared sum.
    `ASSERT_IMPLY(a_spread_nonneg, i_clk, i_rst_n, r_state == B_SPREAD,
        r_ws2 >= r_s1sq, "window spread went negative")

endmodule

>>> rtl/accel_stationary_detector.sv
// ----------------------------------------------------------------------------
// accel_stationary_detector
// Each accepted three-axis sample yields exactly one result: the stationary
// flag, the floored mean of the magnitude window and its floored variance,
// all describing the window after the new magnitude has gone in. The front
// part takes a new sample only once the previous one is pushed: it accepts
// the sample, squares the three axes on the shared squaring multiplier,
// forms the square root bitwise and pushes the magnitude. A four-entry queue
// decouples it from the back part, which steps through its square, sums,
// product, spread and check states, waits on the mean and variance dividers,
// which multiply by reciprocals, and then waits until its result register
// is free. The front part is the slower of the two and sets the sustained
// sample rate. The window starts out filled with one g magnitudes after
// reset through per-entry valid bits, so no clearing pass is needed.
// Configuration writes take effect at once and belong in idle periods.
// ----------------------------------------------------------------------------
module accel_stationary_detector #(
    parameter int WINDOW_LEN = asd_pkg::WINDOW_LEN_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [asd_pkg::ACCEL_W-1:0]  i_accel_x,
    input  logic signed [asd_pkg::ACCEL_W-1:0]  i_accel_y,
    input  logic signed [asd_pkg::ACCEL_W-1:0]  i_accel_z,
    output logic                                empty,
    input  logic                                pop,
    output logic                                o_stationary,
    output logic [asd_pkg::MEAN_W-1:0]          o_mean_magnitude,
    output logic [asd_pkg::VAR_W-1:0]           o_magnitude_variance,
    input  logic                                i_cfg_we,
    input  logic [asd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [asd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import asd_pkg::*;

    t_cfg             r_cfg;
    logic             mag_push;
    logic             mag_full;
    logic [MAG_W-1:0] mag_in;
    logic             mag_pop;
    logic             mag_empty;
    logic [MAG_W-1:0] mag_out;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.var_thresh <= VAR_THRESH_RST;
            r_cfg.mag_thresh <= MAG_THRESH_RST;
            r_cfg.one_g      <= ONE_G_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_VAR_THRESH: r_cfg.var_thresh <= i_cfg_data[VTH_W-1:0];
                CFG_MAG_THRESH: r_cfg.mag_thresh <= i_cfg_data[MTH_W-1:0];
                CFG_ONE_G:      r_cfg.one_g      <= i_cfg_data[ONE_G_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front part: sample to magnitude.
    asd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_accel_x  (i_accel_x),
        .i_accel_y  (i_accel_y),
        .i_accel_z  (i_accel_z),
        .o_full     (full),
        .o_mag_push (mag_push),
        .o_mag      (mag_in),
        .i_mag_full (mag_full)
    );

    // Magnitude queue.
    asd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mag_push),
        .i_data  (mag_in),
        .o_full  (mag_full),
        .i_pop   (mag_pop),
        .o_data  (mag_out),
        .o_empty (mag_empty)
    );

    // Back part: window statistics and result register.
    asd_back #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (r_cfg),
        .i_mag_empty          (mag_empty),
        .i_mag                (mag_out),
        .o_mag_pop            (mag_pop),
        .i_pop                (pop),
        .o_empty              (empty),
        .o_stationary         (o_stationary),
        .o_mean_magnitude     (o_mean_magnitude),
        .o_magnitude_variance (o_magnitude_variance)
    );

endmodule
